[hw/rtl/mft_pkg.sv]
// ----------------------------------------------------------------------------
// mft_pkg: shared types and constants of the motor feedback tracker
// Status codes, item kinds, register indexes and the structs that carry
// configuration, one input item and the tracked motor state.
// ----------------------------------------------------------------------------
package mft_pkg;

  // Motor status codes
  typedef enum logic [1:0] {
    ST_OFFLINE = 2'd0,
    ST_STOP    = 2'd1,
    ST_RUN     = 2'd2,
    ST_STALL   = 2'd3
  } status_e;

  // Item kinds
  typedef enum logic {
    ACT_FRAME = 1'b0,
    ACT_TICK  = 1'b1
  } action_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ENC_RES     = 3'd0,
    CFG_USE_POS     = 3'd1,
    CFG_USE_STALL   = 3'd2,
    CFG_STALL_SRC   = 3'd3,
    CFG_STALL_THR   = 3'd4,
    CFG_STALL_TIME  = 3'd5
  } cfg_idx_e;

  // Stall monitor sources
  typedef enum logic [2:0] {
    SRC_TEMP     = 3'd0,
    SRC_ANGLE    = 3'd1,
    SRC_SPEED    = 3'd2,
    SRC_CURRENT  = 3'd3,
    SRC_POSITION = 3'd4
  } src_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned LimitW   = 13;   // 65535 / 10 fits in 13 bits

  localparam logic [31:0] OFFLINE_MS  = 32'd50;
  localparam logic [16:0] SPEED_STOP  = 17'd100;
  localparam logic [16:0] ENC_RES_RST = 17'h10000;
  localparam logic [2:0]  SRC_RST     = SRC_CURRENT;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam logic [15:0] TICK_DIV_RECIP = 16'd52429;
  localparam int unsigned TickDivShift   = 19;

  typedef struct packed {
    logic [16:0]       enc_res;
    logic              use_pos;
    logic              use_stall;
    logic [2:0]        stall_src;
    logic [30:0]       stall_thr;
    logic [LimitW-1:0] stall_limit;   // stall_time / 10
  } cfg_t;

  typedef struct packed {
    action_e            action;
    logic [31:0]        time_ms;
    logic signed [7:0]  temperature;
    logic signed [15:0] current;
    logic signed [15:0] speed;
    logic signed [15:0] angle;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic [31:0]        last_time;
    logic signed [15:0] prev_angle;
    logic signed [31:0] position;
    logic signed [7:0]  temperature;
    logic signed [15:0] angle;
    logic signed [15:0] speed;
    logic signed [15:0] current;
    logic [15:0]        stall_ticks;
  } state_t;

endpackage

[hw/rtl/mft_next.sv]
// ----------------------------------------------------------------------------
// mft_next: next-state logic of the motor feedback tracker
// Applies one frame or tick to the tracked state: frame storage with angle
// unwrap, offline timeout, stop/run classification and stall counting.
// ----------------------------------------------------------------------------
module mft_next (
  input  mft_pkg::cfg_t   cfg_i,
  input  mft_pkg::item_t  item_i,
  input  mft_pkg::state_t state_i,
  output mft_pkg::state_t state_o
);

  logic        frame_ok;
  logic        capture;
  logic [17:0] delta;
  logic [17:0] delta_mag;
  logic [18:0] delta_ext;
  logic [18:0] res_ext;
  logic [18:0] delta_adj;
  logic [31:0] pos_next;
  logic [31:0] elapsed;
  logic        offline;
  logic [16:0] speed_ext;
  logic [16:0] speed_mag;
  logic [31:0] watched;
  logic [31:0] watched_mag;
  logic [15:0] ticks_inc;
  logic        over_thr;
  mft_pkg::status_e run_state;

  // Frame acceptance and angle unwrap
  assign frame_ok  = (item_i.time_ms >= state_i.last_time);
  assign capture   = (state_i.position == '0) && (state_i.prev_angle == '0);
  assign delta     = {{2{item_i.angle[15]}}, item_i.angle}
                   - {{2{state_i.prev_angle[15]}}, state_i.prev_angle};
  assign delta_mag = delta[17] ? (18'd0 - delta) : delta;
  assign delta_ext = {delta[17], delta};
  assign res_ext   = {2'b00, cfg_i.enc_res};

  always_comb begin
    delta_adj = delta_ext;
    if (delta_mag > {2'b00, cfg_i.enc_res[16:1]}) begin
      delta_adj = delta[17] ? (delta_ext + res_ext) : (delta_ext - res_ext);
    end
  end

  assign pos_next = state_i.position + {{13{delta_adj[18]}}, delta_adj};

  // Heartbeat timing and speed class
  assign elapsed   = item_i.time_ms - state_i.last_time;
  assign offline   = (elapsed > mft_pkg::OFFLINE_MS);
  assign speed_ext = {state_i.speed[15], state_i.speed};
  assign speed_mag = state_i.speed[15] ? (17'd0 - speed_ext) : speed_ext;
  assign run_state = (speed_mag < mft_pkg::SPEED_STOP) ? mft_pkg::ST_STOP
                                                       : mft_pkg::ST_RUN;

  // Watched quantity for the stall monitor
  always_comb begin
    case (mft_pkg::src_e'(cfg_i.stall_src))
      mft_pkg::SRC_TEMP:     watched = {{24{state_i.temperature[7]}}, state_i.temperature};
      mft_pkg::SRC_ANGLE:    watched = {{16{state_i.angle[15]}}, state_i.angle};
      mft_pkg::SRC_SPEED:    watched = {{16{state_i.speed[15]}}, state_i.speed};
      mft_pkg::SRC_CURRENT:  watched = {{16{state_i.current[15]}}, state_i.current};
      mft_pkg::SRC_POSITION: watched = state_i.position;
      default:               watched = '0;
    endcase
  end

  // Unsigned magnitude: the most negative position reads as 2^31
  assign watched_mag = watched[31] ? (32'd0 - watched) : watched;
  assign over_thr    = (watched_mag > {1'b0, cfg_i.stall_thr});
  assign ticks_inc   = (state_i.stall_ticks == 16'hFFFF) ? state_i.stall_ticks
                                                         : (state_i.stall_ticks + 16'd1);

  // State update
  always_comb begin
    state_o = state_i;
    if (item_i.action == mft_pkg::ACT_FRAME) begin
      if (frame_ok) begin
        state_o.temperature = item_i.temperature;
        state_o.current     = item_i.current;
        state_o.speed       = item_i.speed;
        state_o.angle       = item_i.angle;
        state_o.last_time   = item_i.time_ms;
        if (cfg_i.use_pos) begin
          state_o.prev_angle = item_i.angle;
          state_o.position   = capture ? '0 : pos_next;
        end else begin
          state_o.position = '0;
        end
      end
    end else if (offline) begin
      state_o.status = mft_pkg::ST_OFFLINE;
    end else begin
      state_o.status = run_state;
      if (cfg_i.use_stall) begin
        if (over_thr && (run_state == mft_pkg::ST_STOP)) begin
          state_o.stall_ticks = ticks_inc;
          if (ticks_inc > {3'b000, cfg_i.stall_limit}) begin
            state_o.status = mft_pkg::ST_STALL;
          end
        end else begin
          state_o.stall_ticks = '0;
          state_o.status      = mft_pkg::ST_RUN;
        end
      end
    end
  end

endmodule

[hw/rtl/motor_feedback_tracker.sv]
// ----------------------------------------------------------------------------
// motor_feedback_tracker: motor feedback frame and heartbeat tracker
// Stores feedback frames, unwraps the encoder angle into a multi-turn
// position and derives offline / stopped / running / stalled status.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid_i/in_stall_o | action, time_ms, temperature/current/
//          |                       | speed/angle_in
//  out     | out_valid_o/out_stall_i | status, position, temperature, speed,
//          |                       | current, angle
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request per cycle sustained while out_stall_i is low. Each request
// passes through the input register, which captures it, and then the state
// register that drives the result ports, which loads the update. The update
// in mft_next between the two registers is combinational.
// Reset puts status offline and clears all tracked values.
// A stalled result holds the state; the input register then holds its
// request and in_stall_o rises while both registers are full.
// The config port is always ready; stall_time is stored as stall_time / 10.
module motor_feedback_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input requests
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                action_i,
  input  logic [31:0]                         time_ms_i,
  input  logic signed [7:0]                   temperature_in_i,
  input  logic signed [15:0]                  current_in_i,
  input  logic signed [15:0]                  speed_in_i,
  input  logic signed [15:0]                  angle_in_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic signed [31:0]                  position_o,
  output logic signed [7:0]                   temperature_o,
  output logic signed [15:0]                  speed_o,
  output logic signed [15:0]                  current_o,
  output logic signed [15:0]                  angle_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mft_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [mft_pkg::CfgDataW-1:0]        cfg_data_i
);

  logic             in_valid_q;
  logic             in_take;
  logic             advance;
  logic             out_valid_q;
  mft_pkg::item_t   item_q;
  mft_pkg::state_t  state_q;
  mft_pkg::state_t  state_d;
  mft_pkg::cfg_t    cfg_q;
  logic [31:0]      limit_prod;

  // Flow control
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_take || (in_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && out_stall_i);
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action      <= mft_pkg::action_e'(action_i);
      item_q.time_ms     <= time_ms_i;
      item_q.temperature <= temperature_in_i;
      item_q.current     <= current_in_i;
      item_q.speed       <= speed_in_i;
      item_q.angle       <= angle_in_i;
    end
  end

  // Configuration registers; stall_time divided by ten via reciprocal
  assign limit_prod = cfg_data_i[15:0] * mft_pkg::TICK_DIV_RECIP;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enc_res     <= mft_pkg::ENC_RES_RST;
      cfg_q.use_pos     <= 1'b0;
      cfg_q.use_stall   <= 1'b0;
      cfg_q.stall_src   <= mft_pkg::SRC_RST;
      cfg_q.stall_thr   <= '0;
      cfg_q.stall_limit <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mft_pkg::cfg_idx_e'(cfg_index_i))
        mft_pkg::CFG_ENC_RES:    cfg_q.enc_res   <= cfg_data_i[16:0];
        mft_pkg::CFG_USE_POS:    cfg_q.use_pos   <= cfg_data_i[0];
        mft_pkg::CFG_USE_STALL:  cfg_q.use_stall <= cfg_data_i[0];
        mft_pkg::CFG_STALL_SRC:  cfg_q.stall_src <= cfg_data_i[2:0];
        mft_pkg::CFG_STALL_THR:  cfg_q.stall_thr <= cfg_data_i[30:0];
        mft_pkg::CFG_STALL_TIME: begin
          cfg_q.stall_limit <=
            limit_prod[mft_pkg::TickDivShift +: mft_pkg::LimitW];
        end
        default: ;
      endcase
    end
  end

  // Next-state logic
  mft_next u_next (
    .cfg_i   (cfg_q),
    .item_i  (item_q),
    .state_i (state_q),
    .state_o (state_d)
  );

  // Tracked state doubles as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;   // all-zero state: status offline, values cleared
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = state_q.status;
  assign position_o    = state_q.position;
  assign temperature_o = state_q.temperature;
  assign speed_o       = state_q.speed;
  assign current_o     = state_q.current;
  assign angle_o       = state_q.angle;

  // A frame never changes the status
  a_frame_keeps_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.action == mft_pkg::ACT_FRAME)
      |=> (state_q.status == $past(state_q.status)))
    else $error("frame changed motor status");

  // Accepted frame with position off clears the position
  a_pos_off_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.action == mft_pkg::ACT_FRAME && !cfg_q.use_pos
     && item_q.time_ms >= state_q.last_time)
      |=> (state_q.position == '0))
    else $error("position not cleared with accumulation off");

  // Stall counter saturates instead of wrapping
  a_ticks_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.action == mft_pkg::ACT_TICK && state_q.stall_ticks == 16'hFFFF)
      |=> (state_q.stall_ticks == 16'hFFFF || state_q.stall_ticks == '0))
    else $error("stall counter wrapped");

  // A taken result with nothing behind it empties the output
  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !advance) |=> !out_valid_q)
    else $error("result delivered twice");

endmodule
